@@ src/etqt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etqt_pkg
// Shared constants and types for the event timing quantile tracker.
// ----------------------------------------------------------------------------
package etqt_pkg;
    localparam int unsigned QuantileNodes = 15;
    localparam int unsigned TimeW = 64;
    localparam int unsigned StepW = 32;
    localparam int unsigned IdxW = 4;
    localparam int unsigned EwmaWeight = 6;
    localparam logic [StepW-1:0] StepSeedMin = 32'd1024;
    localparam logic [TimeW-1:0] RiseLimit = 64'h0000_0000_FFFF_FFFF;
    localparam logic CmdRecord = 1'b0;
    localparam logic CmdRead = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [TimeW-1:0]    start_time;
        logic [TimeW-1:0]    end_time;
        logic [IdxW-1:0]     node_index;
    } t_in;

    typedef struct packed {
        logic [TimeW-1:0] event_count;
        logic [TimeW-1:0] avg_duration;
        logic [TimeW-1:0] avg_interval;
        logic [TimeW-1:0] peak_duration;
        logic [TimeW-1:0] node_estimate;
        logic [StepW-1:0] node_step;
    } t_out;

    function automatic logic [TimeW-1:0] forward_gap(input logic [TimeW-1:0] later,
                                                     input logic [TimeW-1:0] earlier);
        logic [TimeW-1:0] d;
        d = later - earlier;
        if (d == '0 || d[TimeW-1]) return '0;
        return d;
    endfunction

    function automatic logic [TimeW-1:0] ewma(input logic [TimeW-1:0] avg,
                                              input logic [TimeW-1:0] x);
        logic [TimeW+EwmaWeight:0] s;
        s = ({1'b0, avg, {EwmaWeight{1'b0}}} - {{(EwmaWeight+1){1'b0}}, avg})
            + {{(EwmaWeight+1){1'b0}}, x};
        return s[TimeW+EwmaWeight-1:EwmaWeight];
    endfunction
endpackage
`default_nettype wire

@@ src/etqt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etqt_in_if / etqt_out_if
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface etqt_in_if;
    logic            valid;
    logic            ready;
    etqt_pkg::t_in   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface etqt_out_if;
    logic            valid;
    logic            ready;
    etqt_pkg::t_out  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/etqt_node_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etqt_node_mem
// Quantile node memory: estimate and step per node, one write and one
// registered read port, valid bit per node for reset-to-unset.
// ----------------------------------------------------------------------------
module etqt_node_mem #(
    parameter int unsigned NODES = etqt_pkg::QuantileNodes,
    parameter int unsigned AW = $clog2(NODES + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [AW-1:0]                i_raddr,
    output logic [etqt_pkg::TimeW-1:0]   o_rest,
    output logic [etqt_pkg::StepW-1:0]   o_rstep,
    input  wire                          i_we,
    input  wire  [AW-1:0]                i_waddr,
    input  wire  [etqt_pkg::TimeW-1:0]   i_west,
    input  wire  [etqt_pkg::StepW-1:0]   i_wstep
);
    logic [etqt_pkg::TimeW+etqt_pkg::StepW-1:0] r_mem [NODES];
    logic [NODES-1:0] r_vld;
    logic [etqt_pkg::TimeW+etqt_pkg::StepW-1:0] r_q;
    logic r_qv;

    always_ff @(posedge i_clk) begin
        if (i_we && i_waddr < AW'(NODES)) begin
            r_mem[i_waddr] <= {i_west, i_wstep};
        end
        if (i_raddr < AW'(NODES)) begin
            r_q <= r_mem[i_raddr];
        end else begin
            r_q <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            r_qv <= (i_raddr < AW'(NODES)) && r_vld[i_raddr];
            if (i_we && i_waddr < AW'(NODES)) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rest  = r_qv ? r_q[etqt_pkg::TimeW+etqt_pkg::StepW-1:etqt_pkg::StepW] : '0;
    assign o_rstep = r_qv ? r_q[etqt_pkg::StepW-1:0] : '0;
endmodule
`default_nettype wire

@@ src/event_timing_quantile_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_timing_quantile_tracker
// Event statistics with EWMA averages, peak and a quantile estimate tree.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// i_in     | in  | cmd, start_time, end_time, node_index
// o_out    | out | event_count, avg/peak stats, node_estimate, node_step
// A read passes through S_FIN, S_CAP and S_OUT back to idle; a record
// visits one tree level per S_UPD, with S_RD between levels, then S_FIN,
// S_CAP and S_OUT. The registered node memory read, its single write port
// and the read-back of the reported node shape this sequence. Synchronous
// active-low reset. One transaction in flight; the input stalls while a
// result waits.
// ----------------------------------------------------------------------------
module event_timing_quantile_tracker #(
    parameter int unsigned QUANTILE_NODES = etqt_pkg::QuantileNodes
) (
    input wire          i_clk,
    input wire          i_rst_n,
    etqt_in_if.sink     i_in,
    etqt_out_if.source  o_out
);
    localparam int unsigned AW = $clog2(QUANTILE_NODES + 1);
    localparam int unsigned TW = etqt_pkg::TimeW;
    localparam int unsigned SW = etqt_pkg::StepW;
    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_UPD = 3'd2,
                           S_FIN = 3'd3, S_OUT = 3'd4, S_CAP = 3'd5;

    logic [2:0]     r_st, n_st;
    logic [TW-1:0]  r_cnt, r_avgd, r_avgi, r_peak, r_prev, r_dur;
    logic [AW-1:0]  r_node, n_node;
    logic [etqt_pkg::IdxW-1:0] r_idx;
    etqt_pkg::t_out r_res;

    logic [AW-1:0]  raddr;
    logic [TW-1:0]  mest, west, gap_abs;
    logic [SW-1:0]  mstep, wstep, half;
    logic           we, done, idx_ok;
    logic [TW:0]    sum;

    etqt_node_mem #(.NODES(QUANTILE_NODES), .AW(AW)) u_mem (
        .i_clk, .i_rst_n, .i_raddr(raddr), .o_rest(mest), .o_rstep(mstep),
        .i_we(we), .i_waddr(r_node), .i_west(west), .i_wstep(wstep)
    );

    always_comb begin
        half = r_dur[SW:1];
        sum  = {1'b0, mest} + {{(TW-SW+1){1'b0}}, mstep};
        west = mest;
        wstep = mstep;
        if (mstep == '0) begin
            west  = r_dur;
            wstep = (half > etqt_pkg::StepSeedMin) ? half : etqt_pkg::StepSeedMin;
        end else if (mest > r_dur) begin
            west = (mest >= {{(TW-SW){1'b0}}, mstep}) ? mest - {{(TW-SW){1'b0}}, mstep} : '0;
        end else if (mest < r_dur) begin
            west = sum[TW] ? etqt_pkg::RiseLimit : sum[TW-1:0];
        end
        gap_abs = (west > r_dur) ? west - r_dur : r_dur - west;
        if (gap_abs < {{(TW-SW){1'b0}}, wstep}) begin
            wstep = ({1'b0, wstep[SW-1:1]} > SW'(1)) ? {1'b0, wstep[SW-1:1]} : SW'(1);
        end
        done = (r_dur >= west) || ({1'b0, r_node, 1'b1} >= (AW+2)'(QUANTILE_NODES));
        we = (r_st == S_UPD);
        n_node = done ? r_node : AW'({r_node, 1'b1});
        idx_ok = (32'(r_idx) < QUANTILE_NODES);
        case (r_st)
            S_IDLE: raddr = '0;
            S_UPD:  raddr = n_node;
            S_FIN:  raddr = idx_ok ? AW'(r_idx) : AW'(QUANTILE_NODES);
            default: raddr = r_node;
        endcase
    end

    assign i_in.ready  = (r_st == S_IDLE);
    assign o_out.valid = (r_st == S_OUT);
    assign o_out.data  = r_res;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_in.valid) n_st = (i_in.data.cmd == etqt_pkg::CmdRecord) ? S_UPD : S_FIN;
            S_RD:   n_st = S_UPD;
            S_UPD:  n_st = done ? S_FIN : S_RD;
            S_FIN:  n_st = S_CAP;
            S_CAP:  n_st = S_OUT;
            S_OUT:  if (o_out.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0; r_avgd <= '0; r_avgi <= '0; r_peak <= '0; r_prev <= '0;
            r_node <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_IDLE && i_in.valid) begin
                r_idx <= i_in.data.node_index;
                r_node <= '0;
                if (i_in.data.cmd == etqt_pkg::CmdRecord) begin
                    r_dur <= etqt_pkg::forward_gap(i_in.data.end_time, i_in.data.start_time);
                    r_cnt <= r_cnt + TW'(1);
                    r_avgd <= (r_avgd != '0) ? etqt_pkg::ewma(r_avgd,
                        etqt_pkg::forward_gap(i_in.data.end_time, i_in.data.start_time))
                        : etqt_pkg::forward_gap(i_in.data.end_time, i_in.data.start_time);
                    r_avgi <= (r_avgi != '0) ? etqt_pkg::ewma(r_avgi,
                        etqt_pkg::forward_gap(i_in.data.end_time, r_prev))
                        : etqt_pkg::forward_gap(i_in.data.end_time, r_prev);
                    if (etqt_pkg::forward_gap(i_in.data.end_time, i_in.data.start_time) > r_peak)
                        r_peak <= etqt_pkg::forward_gap(i_in.data.end_time, i_in.data.start_time);
                    r_prev <= i_in.data.end_time;
                end
            end
            if (r_st == S_UPD) r_node <= n_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_CAP) begin
            r_res.event_count   <= r_cnt;
            r_res.avg_duration  <= r_avgd;
            r_res.avg_interval  <= r_avgi;
            r_res.peak_duration <= r_peak;
            r_res.node_estimate <= mest;
            r_res.node_step     <= mstep;
        end
    end

`ifndef SYNTH
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("ready and valid both high");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(r_res)) else $error("result moved");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.data.cmd == etqt_pkg::CmdRead |=> $stable(r_cnt))
        else $error("read changed count");
`endif
endmodule
`default_nettype wire
